/* src/hsf_pkg.sv */
// Package for the scaled forward block: widths, defaults and the ln table.
// No dependencies.
package hsf_pkg;
    localparam int MAX_STATES_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int VAL_W          = 24;
    localparam int LOG_W          = 32;
    localparam int LN2_Q16        = 45426;

    typedef enum logic [1:0] {
        KIND_TRANS = 2'd0,
        KIND_INIT  = 2'd1,
        KIND_EMIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // ln(1 + i/16) in Q16.16
    function automatic logic [16:0] ln_tab(input logic [4:0] i);
        case (i)
            5'd0: ln_tab = 17'd0;
            5'd1: ln_tab = 17'd3973;
            5'd2: ln_tab = 17'd7719;
            5'd3: ln_tab = 17'd11262;
            5'd4: ln_tab = 17'd14624;
            5'd5: ln_tab = 17'd17821;
            5'd6: ln_tab = 17'd20870;
            5'd7: ln_tab = 17'd23783;
            5'd8: ln_tab = 17'd26573;
            5'd9: ln_tab = 17'd29248;
            5'd10: ln_tab = 17'd31818;
            5'd11: ln_tab = 17'd34292;
            5'd12: ln_tab = 17'd36675;
            5'd13: ln_tab = 17'd38975;
            5'd14: ln_tab = 17'd41196;
            5'd15: ln_tab = 17'd43345;
            5'd16: ln_tab = 17'd45426;
            default: ln_tab = 17'd0;
        endcase
    endfunction
endpackage

/* src/hmm_scaled_forward_top.sv */
// Scaled HMM forward recursion, top level and only datapath module.
// Depends on hsf_pkg.
//
// Usage: load transitions (kind 0) and initial probabilities (kind 1), then
// stream emissions (kind 2) state by state. An emission at the first step of a
// sequence takes one multiplier pass; otherwise the one shared 32x32 multiplier
// first walks the N predecessor alphas (table read, product, then accumulate).
// The emission of the last used state also runs the step close: one restoring
// division per state (load, 32+FRAC_BITS quotient bits at one a cycle through
// a single subtractor, write back), a leading-one search and one multiplier
// pass for ln; a zero scale instead closes the step as impossible. s_ready is
// low while an item is in work; a finished result waits in the output register
// while the next items are taken, and a later result holds in the last stage
// until the register is free. Weights are stored with FRAC_BITS fraction bits;
// alphas are normalized so their sum is close to one.
module hmm_scaled_forward_top
    import hsf_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [2:0]          s_to_state,
    input  logic [2:0]          s_from_state,
    input  logic [VAL_W-1:0]    s_value,
    input  logic                s_seq_start,
    input  logic                s_seq_end,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [LOG_W-1:0] m_log_likelihood,
    output logic                m_status,
    output logic                m_seq_last
);
    localparam int SW   = $clog2(MAX_STATES);
    localparam int CW   = $clog2(MAX_STATES + 1);
    localparam int TW   = 2 * SW;
    localparam int PW   = FRAC_BITS;
    localparam int DW   = 32 + FRAC_BITS;
    localparam logic [PW-1:0] PMAX = {PW{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_EMUL, ST_STORE,
        ST_DIV_LD, ST_DIV, ST_DIV_WR, ST_LZ, ST_LNMUL, ST_LNFIN, ST_OUT
    } state_t;

    state_t state_reg;

    logic [PW-1:0]   trans_mem [MAX_STATES*MAX_STATES];
    logic [PW-1:0]   init_mem  [MAX_STATES];
    logic [PW-1:0]   aprev_reg [MAX_STATES];
    logic [31:0]     anew_reg  [MAX_STATES];
    logic [31:0]     scale_reg;
    logic signed [LOG_W-1:0] logacc_reg;
    logic            failed_reg;
    logic [3:0]      nstates_reg;

    logic [SW-1:0]   to_reg, idx_reg;
    logic [VAL_W-1:0] val_reg;
    logic            start_reg, end_reg;
    logic [PW-1:0]   trd_reg;
    logic [63:0]     prod_reg;
    logic [63:0]     acc_reg;
    logic [DW-1:0]   num_reg;
    logic [32:0]     rem_reg;
    logic [DW-1:0]   quo_reg;
    logic [6:0]      cnt_reg;
    logic [4:0]      k_reg;
    logic [31:0]     mant_reg;
    logic signed [LOG_W-1:0] ln_reg;
    logic            fail_res_reg;

    logic [CW-1:0] n_used;
    always_comb begin
        if (nstates_reg == 4'd0) n_used = CW'(1);
        else if (32'(nstates_reg) > MAX_STATES) n_used = CW'(MAX_STATES);
        else n_used = CW'(nstates_reg);
    end

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        mul_a = 32'(trd_reg);
        mul_b = 32'(aprev_reg[idx_reg]);
        case (state_reg)
            ST_EMUL:  begin
                mul_a = start_reg ? 32'(init_mem[to_reg])
                                  : 32'(acc_reg >> FRAC_BITS);
                mul_b = 32'(val_reg);
            end
            ST_LNMUL: begin
                mul_a = 32'(ln_tab({1'b0, mant_reg[30:27]} + 5'd1)
                            - ln_tab({1'b0, mant_reg[30:27]}));
                mul_b = 32'(mant_reg[26:11]);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [33:0] div_try;
    assign div_try = {1'b0, rem_reg[31:0], num_reg[DW-1]} - {2'b0, scale_reg};

    logic [63:0] emul_sh;
    assign emul_sh = prod_reg >> FRAC_BITS;

    logic signed [63:0] ln_full, acc_full;
    assign ln_full = 64'(signed'({1'b0, k_reg})) * 64'sd0
                     + (64'(signed'({1'b0, k_reg})) - 64'(FRAC_BITS)) * 64'(LN2_Q16)
                     + 64'(ln_tab({1'b0, mant_reg[30:27]}))
                     + 64'(prod_reg >> 16);
    assign acc_full = start_reg ? 64'(ln_reg) : 64'(logacc_reg) + 64'(ln_reg);

    logic [31:0] ln_sat, acc_sat;
    always_comb begin
        if (ln_full > 64'sd2147483647) ln_sat = 32'h7FFFFFFF;
        else if (ln_full < -64'sd2147483648) ln_sat = 32'h80000000;
        else ln_sat = ln_full[31:0];
        if (acc_full > 64'sd2147483647) acc_sat = 32'h7FFFFFFF;
        else if (acc_full < -64'sd2147483648) acc_sat = 32'h80000000;
        else acc_sat = acc_full[31:0];
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid     <= 1'b0;
            failed_reg  <= 1'b0;
            scale_reg   <= '0;
            logacc_reg  <= '0;
            nstates_reg <= 4'd8;
            for (int i = 0; i < MAX_STATES; i++) begin
                aprev_reg[i] <= '0;
                anew_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) nstates_reg <= cfg_data;
            if (m_valid && m_ready && state_reg != ST_OUT) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        to_reg    <= SW'(s_to_state);
                        val_reg   <= s_value;
                        start_reg <= s_seq_start;
                        end_reg   <= s_seq_end;
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                        case (kind_t'(s_kind))
                            KIND_TRANS: begin
                                if (32'(s_to_state) < MAX_STATES &&
                                    32'(s_from_state) < MAX_STATES)
                                    trans_mem[TW'(32'(s_to_state) * MAX_STATES
                                              + 32'(s_from_state))] <=
                                        (s_value > VAL_W'(PMAX)) ? PMAX : PW'(s_value);
                            end
                            KIND_INIT: begin
                                if (32'(s_to_state) < MAX_STATES)
                                    init_mem[SW'(s_to_state)] <=
                                        (s_value > VAL_W'(PMAX)) ? PMAX : PW'(s_value);
                            end
                            KIND_EMIT: begin
                                if (32'(s_to_state) < 32'(n_used) &&
                                    (!failed_reg || s_seq_start)) begin
                                    if (s_seq_start) failed_reg <= 1'b0;
                                    if (s_to_state == 3'd0) scale_reg <= '0;
                                    state_reg <= s_seq_start ? ST_EMUL : ST_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD: begin
                    trd_reg   <= trans_mem[TW'(32'(to_reg) * MAX_STATES + 32'(idx_reg))];
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= acc_reg + prod_reg;
                    if (32'(idx_reg) == 32'(n_used) - 1) state_reg <= ST_EMUL;
                    else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_EMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    // saturate alpha, add to scale, then check step close
                    logic [31:0] a;
                    logic [32:0] s;
                    a = (emul_sh > 64'hFFFFFFFF) ? 32'hFFFFFFFF : emul_sh[31:0];
                    s = {1'b0, scale_reg} + 33'(a);
                    anew_reg[to_reg] <= a;
                    scale_reg <= s[32] ? 32'hFFFFFFFF : s[31:0];
                    if (32'(to_reg) != 32'(n_used) - 1) state_reg <= ST_IDLE;
                    else if (s == 33'd0) begin
                        failed_reg   <= 1'b1;
                        fail_res_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end else begin
                        fail_res_reg <= 1'b0;
                        idx_reg      <= '0;
                        state_reg    <= ST_DIV_LD;
                    end
                end
                ST_DIV_LD: begin
                    num_reg   <= {anew_reg[idx_reg], {FRAC_BITS{1'b0}}};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= 7'(DW);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // one restoring quotient bit per cycle
                    if (!div_try[33]) begin
                        rem_reg <= div_try[32:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[31:0], num_reg[DW-1]};
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 7'd1) state_reg <= ST_DIV_WR;
                end
                ST_DIV_WR: begin
                    aprev_reg[idx_reg] <= (quo_reg > DW'(PMAX)) ? PMAX : PW'(quo_reg);
                    if (32'(idx_reg) == 32'(n_used) - 1) begin
                        k_reg     <= 5'd31;
                        mant_reg  <= scale_reg;
                        state_reg <= ST_LZ;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_DIV_LD;
                    end
                end
                ST_LZ: begin
                    // normalize one bit per cycle
                    if (mant_reg[31] || k_reg == 5'd0) state_reg <= ST_LNMUL;
                    else begin
                        mant_reg <= mant_reg << 1;
                        k_reg    <= k_reg - 1'b1;
                    end
                end
                ST_LNMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_LNFIN;
                end
                ST_LNFIN: begin
                    ln_reg    <= signed'(ln_sat);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold here until the output register is free
                    if (!m_valid || m_ready) begin
                        if (fail_res_reg) m_log_likelihood <= 32'sh80000000;
                        else begin
                            logacc_reg       <= signed'(acc_sat);
                            m_log_likelihood <= signed'(acc_sat);
                            scale_reg        <= '0;
                        end
                        m_status   <= fail_res_reg;
                        m_seq_last <= end_reg;
                        m_valid    <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

/* src/hsf_checker.sv */
// Port-level checker for the scaled forward block, bound to the top level.
// Depends on hsf_pkg.
module hsf_checker
    import hsf_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic signed [LOG_W-1:0] m_log_likelihood,
    input logic m_status
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_log_likelihood))
        else $error("result dropped while stalled");
    a_hold_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_status))
        else $error("status changed while stalled");
    a_fail_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_log_likelihood == 32'sh80000000)
        else $error("impossible result without minimum log likelihood");
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result in the cycle right after an accept");
endmodule

bind hmm_scaled_forward_top hsf_checker u_hsf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_log_likelihood(m_log_likelihood), .m_status(m_status)
);

/* tb/hmm_scaled_forward_top_test.sv */
// Self-checking testbench for hmm_scaled_forward_top: random and directed items,
// with a built-in predictor of the scaled forward recursion.
// Depends on hsf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module hmm_scaled_forward_top_test;
    import hsf_pkg::*;

    localparam int NST       = 8;
    localparam int FRAC      = 16;
    localparam int DRAIN_CYC = 700;    // one full step close at eight states, with margin
    localparam int WDOG_MAX  = 30000;  // longest quiet stretch: long hold plus a drain pause

    typedef struct {
        kind_t            kind;
        logic [2:0]       to_st;
        logic [2:0]       from_st;
        logic [VAL_W-1:0] value;
        logic             start;
        logic             last;
    } fwd_item_t;

    typedef struct {
        logic signed [LOG_W-1:0] loglik;
        logic                    status;
        logic                    last;
    } step_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic [2:0] s_to_state = '0;
    logic [2:0] s_from_state = '0;
    logic [VAL_W-1:0] s_value = '0;
    logic s_seq_start = 1'b0;
    logic s_seq_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b1;
    logic signed [LOG_W-1:0] m_log_likelihood;
    logic m_status;
    logic m_seq_last;

    hmm_scaled_forward_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_to_state      (s_to_state),
        .s_from_state    (s_from_state),
        .s_value         (s_value),
        .s_seq_start     (s_seq_start),
        .s_seq_end       (s_seq_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_log_likelihood(m_log_likelihood),
        .m_status        (m_status),
        .m_seq_last      (m_seq_last)
    );

    always #5 aclk = ~aclk;

    // Stimulus and expectation stores
    fwd_item_t    pending_items[$];
    step_result_t expected_steps[$];

    int  tx_idle_pct = 6;
    int  rx_idle_pct = 60;
    bit  long_hold_go = 1'b0;
    int  n_errors = 0;
    int  n_items = 0;
    int  n_steps = 0;
    int  n_impossible = 0;
    int  n_pushed = 0;
    int  quiet_cycles = 0;
    bit  s_took = 1'b0;

    // Predictor state: mirrors the block's tables, alphas and accumulators
    logic [15:0] pr_trans [NST*NST];
    logic [15:0] pr_init  [NST];
    logic [15:0] pr_alpha [NST];
    logic [31:0] pr_alpha_new [NST];
    logic [31:0] pr_scale;
    logic signed [31:0] pr_log;
    bit          pr_failed;
    logic [3:0]  pr_nstates;

    // ln(1 + i/16) in Q16.16
    const int ln_pts[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                             29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

    function automatic logic [15:0] clip_prob(longint unsigned v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic longint ln_q16(logic [31:0] s);
        int k;
        logic [31:0] mant;
        int idx;
        longint rem;
        longint lm;
        k = 31;
        while (k > 0 && s[k] == 1'b0) k--;
        mant = s << (31 - k);
        idx = mant[30:27];
        rem = mant[26:11];
        lm = ln_pts[idx] + (((ln_pts[idx+1] - ln_pts[idx]) * rem) >>> 16);
        return longint'(k - FRAC) * LN2_Q16 + lm;
    endfunction

    function automatic logic signed [31:0] clip_s32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Advance the predictor by one item; return 1 when the item closes a step.
    function automatic bit forward_step(fwd_item_t it, output step_result_t res);
        int n;
        longint unsigned a;
        longint unsigned acc;
        n = (pr_nstates == 0) ? 1 : (pr_nstates > NST) ? NST : pr_nstates;
        res = '{0, 0, 0};
        if (it.kind == KIND_TRANS) begin
            pr_trans[it.to_st*NST + it.from_st] = clip_prob(it.value);
            return 0;
        end
        if (it.kind == KIND_INIT) begin
            pr_init[it.to_st] = clip_prob(it.value);
            return 0;
        end
        if (it.kind != KIND_EMIT || it.to_st >= n) return 0;
        if (pr_failed && !it.start) return 0;
        if (it.start) pr_failed = 0;
        if (it.to_st == 0) pr_scale = 0;
        if (it.start) begin
            a = (longint'(pr_init[it.to_st]) * it.value) >> FRAC;
        end else begin
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += longint'(pr_trans[it.to_st*NST + i]) * pr_alpha[i];
            a = ((acc >> FRAC) * it.value) >> FRAC;
        end
        if (a > 64'hFFFFFFFF) a = 64'hFFFFFFFF;
        pr_alpha_new[it.to_st] = a[31:0];
        a += pr_scale;
        pr_scale = (a > 64'hFFFFFFFF) ? 32'hFFFFFFFF : a[31:0];
        if (it.to_st != n - 1) return 0;
        if (pr_scale == 0) begin
            pr_failed = 1;
            res = '{32'sh80000000, 1'b1, it.last};
            return 1;
        end
        for (int i = 0; i < n; i++)
            pr_alpha[i] = clip_prob((longint'(pr_alpha_new[i]) << FRAC) / pr_scale);
        if (it.start) pr_log = clip_s32(ln_q16(pr_scale));
        else          pr_log = clip_s32(longint'(pr_log) + ln_q16(pr_scale));
        pr_scale = 0;
        res = '{pr_log, 1'b0, it.last};
        return 1;
    endfunction

    // Driver: present the next pending item at the falling edge, or idle.
    always @(negedge aclk) begin
        fwd_item_t it;
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = pending_items.pop_front();
                s_valid      <= 1'b1;
                s_kind       <= it.kind;
                s_to_state   <= it.to_st;
                s_from_state <= it.from_st;
                s_value      <= it.value;
                s_seq_start  <= it.start;
                s_seq_end    <= it.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold counted here
    always @(negedge aclk) begin
        static int hold_left = 0;
        static bit hold_used = 1'b0;
        if (long_hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 4000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predict on accepted items, check accepted results, run the watchdog
    always @(posedge aclk) begin
        fwd_item_t    it;
        step_result_t res;
        step_result_t want;
        if (aresetn) begin
            s_took <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) pr_nstates = cfg_data;
            if (m_valid && m_ready) begin
                n_steps++;
                if (m_status) n_impossible++;
                if (expected_steps.size() == 0) begin
                    $error("unexpected result: loglik %0d status %0d last %0d",
                           m_log_likelihood, m_status, m_seq_last);
                    n_errors++;
                end else begin
                    want = expected_steps.pop_front();
                    if (m_log_likelihood !== want.loglik) begin
                        $error("log_likelihood: expected %0d, got %0d",
                               want.loglik, m_log_likelihood);
                        n_errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        n_errors++;
                    end
                    if (m_seq_last !== want.last) begin
                        $error("seq_last: expected %0d, got %0d", want.last, m_seq_last);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                n_items++;
                it = '{kind_t'(s_kind), s_to_state, s_from_state, s_value,
                       s_seq_start, s_seq_end};
                if (forward_step(it, res)) expected_steps.push_back(res);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("timeout: no handshake for %0d cycles", WDOG_MAX);
                $display("** hmm_scaled_forward_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [VAL_W-1:0] emission_value();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return '0;
        if (r < 10) return VAL_W'($urandom);
        return VAL_W'($urandom_range(1, 24'h3FFFF));
    endfunction

    function automatic logic [VAL_W-1:0] prob_value();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return VAL_W'($urandom);        // above one: saturates on load
        if (r < 10) return '0;
        return VAL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic add_item(kind_t k, int to_st, int from_st, logic [VAL_W-1:0] v,
                            bit st, bit lst);
        pending_items.push_back('{k, 3'(to_st), 3'(from_st), v, st, lst});
        n_pushed++;
    endtask

    task automatic load_tables();
        for (int t = 0; t < NST; t++) begin
            for (int f = 0; f < NST; f++)
                add_item(KIND_TRANS, t, f, prob_value(), 1'($urandom), 1'($urandom));
            add_item(KIND_INIT, t, $urandom_range(7), prob_value(), 1'($urandom),
                     1'($urandom));
        end
    endtask

    // One well-formed sequence with random content; sometimes broken or impossible
    task automatic add_sequence(int n);
        int  len;
        bit  dead;
        len = $urandom_range(1, 6);
        for (int t = 0; t < len; t++) begin
            dead = ($urandom_range(19) == 0);
            for (int s = 0; s < n; s++) begin
                if ($urandom_range(49) == 0) continue;   // drop a state now and then
                add_item(KIND_EMIT, s, $urandom_range(7), dead ? '0 : emission_value(),
                         t == 0, t == len - 1);
            end
        end
    endtask

    task automatic add_noise(int n);
        case ($urandom_range(3))
            0: add_item(KIND_NONE, $urandom_range(7), $urandom_range(7), VAL_W'($urandom),
                        1'($urandom), 1'($urandom));
            1: add_item(KIND_TRANS, $urandom_range(7), $urandom_range(7), prob_value(),
                        1'($urandom), 1'($urandom));
            2: add_item(KIND_INIT, $urandom_range(7), $urandom_range(7), prob_value(),
                        1'($urandom), 1'($urandom));
            default: add_item(KIND_EMIT, $urandom_range(7), $urandom_range(7),
                              emission_value(), 1'($urandom), 1'($urandom));
        endcase
    endtask

    // Hold until every item is sent and every result is in, then let the block settle
    task automatic wait_drain();
        while (pending_items.size() > 0 || s_valid || expected_steps.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_num_states(logic [3:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [3:0] phase_cfg[6] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd1, 4'd5};
        int n;
        pr_scale = 0;
        pr_log = 0;
        pr_failed = 0;
        pr_nstates = 4'd8;
        foreach (pr_alpha[i]) begin
            pr_alpha[i] = 0;
            pr_alpha_new[i] = 0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every table entry before any emission reads one
        load_tables();
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 60 : 0;
            rx_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 6 : 0;
            write_num_states(phase_cfg[ph]);
            n = (phase_cfg[ph] == 0) ? 1 : (phase_cfg[ph] > NST) ? NST : phase_cfg[ph];
            if (ph == 0) begin
                // Directed: ignored kind, saturating load, unused state, impossible
                // sequence and the items it swallows, extreme emissions
                add_item(KIND_NONE, 7, 7, '1, 1'b1, 1'b1);
                add_item(KIND_TRANS, 0, 0, '1, 1'b0, 1'b0);
                add_item(KIND_INIT, 7, 0, '1, 1'b0, 1'b0);
                add_item(KIND_EMIT, 5, 0, 24'h010000, 1'b1, 1'b0);
                for (int s = 0; s < 3; s++) add_item(KIND_EMIT, s, 0, '0, 1'b1, 1'b0);
                for (int s = 0; s < 3; s++) add_item(KIND_EMIT, s, 0, '1, 1'b0, 1'b1);
                for (int s = 0; s < 3; s++) add_item(KIND_EMIT, s, 7, '1, 1'b1, 1'b0);
                for (int s = 0; s < 3; s++)
                    add_item(KIND_EMIT, s, 0, 24'h000001, 1'b0, 1'b0);
                for (int s = 0; s < 3; s++) add_item(KIND_EMIT, s, 0, '1, 1'b0, 1'b1);
            end
            while (n_pushed < 72 + (ph + 1) * 222) begin
                if ($urandom_range(9) < 8) add_sequence(n);
                else add_noise(n);
                if (ph == 1 && !long_hold_go && n_pushed > 72 + 260) long_hold_go = 1'b1;
                if (ph == 3 && $urandom_range(29) == 0) wait_drain();
            end
            wait_drain();
        end

        $display("run covered %0d items and %0d step results (%0d impossible)",
                 n_items, n_steps, n_impossible);
        $display("state counts 0, 1, 3, 5, 8 and 15 with both idle patterns and none");
        if (n_errors == 0)
            $display("** hmm_scaled_forward_top: PASSED **");
        else
            $display("** hmm_scaled_forward_top: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
src/hsf_pkg.sv
src/hmm_scaled_forward_top.sv
src/hsf_checker.sv
tb/hmm_scaled_forward_top_test.sv
